// ===== hdl/lgu_pkg.sv =====
// Shared types and codes for the life grid core with obstacles and undo.
// No dependencies; used by hdl/life_grid_with_obstacles_undo_core.sv.
package lgu_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR,
      ST_RD,
      ST_COPY,
      ST_LIFE,
      ST_REST,
      ST_CMP,
      ST_RSP
   } st_type;

   // request kinds
   localparam logic [2:0] REQ_GUARD = 3'd0;
   localparam logic [2:0] REQ_LOAD  = 3'd1;
   localparam logic [2:0] REQ_CLEAR = 3'd2;
   localparam logic [2:0] REQ_STEP  = 3'd3;
   localparam logic [2:0] REQ_UNDO  = 3'd4;
   localparam logic [2:0] REQ_READ  = 3'd5;

   // cell codes
   localparam logic [1:0] CELL_EMPTY = 2'd0;
   localparam logic [1:0] CELL_ALIVE = 2'd1;
   localparam logic [1:0] CELL_OBST  = 2'd2;
   localparam logic [1:0] CELL_RSVD  = 2'd3;

   // configuration register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

endpackage

// ===== hdl/life_grid_with_obstacles_undo_core.sv =====
// Life grid core: cell grid with obstacles, single-step Life update and undo ring.
// Depends on hdl/lgu_pkg.sv (state type, request and cell codes).
//
// The block holds a MAX_ROWS x MAX_COLS grid of 2-bit cells (empty, alive,
// obstacle) in an on-chip memory and a ring of HIST_DEPTH saved grids in a
// second memory. Requests arrive one at a time on the req_ stream; every
// request returns exactly one item on the rsp_ stream. A single sequencer
// drives both memories, one read and one write per memory per cycle, so
// the cost of a request is set by how many cells it must sweep (N is
// MAX_ROWS*MAX_COLS, R x C the area in use):
//   reset       : clearing pass over all N cells of the grid memory, no items taken
//   clear history, undo with empty history, out-of-range, unused kind
//               : no sweep
//   read        : one grid read, no sweep
//   write/load  : no sweep when the cell is not written (unchanged or guarded),
//                 else an N-cell recheck of stability against the newest saved grid
//   step        : N-cell copy into the ring, then nine reads of the saved copy per
//                 cell of R x C for the neighbor count, then an N-cell compare
//   undo        : N-cell copy back from the ring plus N-cell compare
// The result register frees the sequencer once a result is loaded; ready is
// high only while the sequencer waits for a new item.
module life_grid_with_obstacles_undo_core #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int HIST_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: req_type[2:0], row_index[7:3], col_index[12:8], cell_value[14:13]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lgu_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: read_value[1:0], is_stable[2], undo_failed[3], out_of_range[4],
   //            history_count[7:5]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lgu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [5:0]                     csr_wdata
);

   localparam int NCELLS = MAX_ROWS * MAX_COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int CNTW   = AW + 1;
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int EWR    = $clog2(MAX_ROWS + 1);
   localparam int EWC    = $clog2(MAX_COLS + 1);
   localparam int SZRW   = (EWR > 6) ? EWR : 6;
   localparam int SZCW   = (EWC > 6) ? EWC : 6;
   localparam int SW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int FW     = $clog2(HIST_DEPTH + 1);
   localparam int HAW    = $clog2(HIST_DEPTH * NCELLS);
   localparam int HDEPTH = HIST_DEPTH * NCELLS;

   function automatic logic [HAW-1:0] hist_addr(input logic [SW-1:0] s,
                                                input logic [AW-1:0] i);
      hist_addr = HAW'(s) * HAW'(NCELLS) + HAW'(i);
   endfunction

   // ---------------------------------------------------------------- state
   lgu_pkg::st_type state_ff, state_in;

   logic [5:0]      rows_cfg_ff, cols_cfg_ff;
   logic [SZRW-1:0] rows_eff;
   logic [SZCW-1:0] cols_eff;

   logic [2:0]      type_ff;
   logic [1:0]      val_ff;
   logic [AW-1:0]   addr_ff;
   logic            res_oor_ff, res_fail_ff;
   logic [1:0]      res_read_ff;

   logic [SW-1:0]   top_ff, lslot_ff, top_inc, top_dec;
   logic [FW-1:0]   fill_ff;
   logic            stable_ff;

   logic [CNTW-1:0] cnt_ff;
   logic            pend_ff;
   logic [AW-1:0]   paddr_ff;
   logic            mism_ff;
   logic            sweep_done;

   logic [RW-1:0]   r_ff;
   logic [CW-1:0]   c_ff;
   logic [3:0]      k_ff;
   logic [3:0]      ncnt_ff;
   logic [1:0]      ctr_ff;
   logic            dv_ff, dcen_ff;

   logic            rsp_valid_ff;
   logic [1:0]      rsp_read_ff;
   logic            rsp_stable_ff, rsp_fail_ff, rsp_oor_ff;
   logic [2:0]      rsp_cnt_ff;
   logic            rsp_load;

   // memories
   logic [1:0]      grid_mem [NCELLS];
   logic [1:0]      hist_mem [HDEPTH];
   logic            grid_we, hist_we;
   logic [AW-1:0]   grid_wa, grid_ra;
   logic [HAW-1:0]  hist_wa, hist_ra;
   logic [1:0]      grid_wd, hist_wd, grid_rd, hist_rd;

   // ---------------------------------------------------------- input decode
   logic [2:0]      in_type;
   logic [4:0]      in_row, in_col;
   logic [1:0]      in_val;
   logic            in_addressed, in_inside;
   logic [AW-1:0]   in_addr;

   assign in_type = req_tdata[2:0];
   assign in_row  = req_tdata[7:3];
   assign in_col  = req_tdata[12:8];
   assign in_val  = req_tdata[14:13];

   always_comb begin
      if (rows_cfg_ff == 6'd0) begin
         rows_eff = SZRW'(1);
      end else if (SZRW'(rows_cfg_ff) > SZRW'(MAX_ROWS)) begin
         rows_eff = SZRW'(MAX_ROWS);
      end else begin
         rows_eff = SZRW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == 6'd0) begin
         cols_eff = SZCW'(1);
      end else if (SZCW'(cols_cfg_ff) > SZCW'(MAX_COLS)) begin
         cols_eff = SZCW'(MAX_COLS);
      end else begin
         cols_eff = SZCW'(cols_cfg_ff);
      end
   end

   assign in_addressed = (in_type == lgu_pkg::REQ_GUARD) || (in_type == lgu_pkg::REQ_LOAD)
                         || (in_type == lgu_pkg::REQ_READ);
   assign in_inside    = (SZRW'(in_row) < rows_eff) && (SZCW'(in_col) < cols_eff);
   assign in_addr      = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);

   assign top_inc = (top_ff == SW'(HIST_DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dec = (top_ff == '0) ? SW'(HIST_DEPTH - 1) : top_ff - 1'b1;

   assign sweep_done = (cnt_ff == CNTW'(NCELLS)) && !pend_ff;

   // ------------------------------------------------ guarded write decision
   logic do_write;
   always_comb begin
      do_write = 1'b0;
      if (type_ff == lgu_pkg::REQ_LOAD) begin
         do_write = (val_ff != lgu_pkg::CELL_RSVD);
      end else if (type_ff == lgu_pkg::REQ_GUARD) begin
         do_write = (val_ff == lgu_pkg::CELL_OBST) ||
                    ((val_ff != lgu_pkg::CELL_RSVD) && (grid_rd != lgu_pkg::CELL_OBST));
      end
   end

   // ---------------------------------------------- neighbor walk of a step
   // k walks the 3x3 window row by row; k == 4 is the cell itself.
   logic            rlo, rhi, clo, chi, nb_in;
   logic [SZRW-1:0] r_p1;
   logic [SZCW-1:0] c_p1;
   logic [RW-1:0]   nr;
   logic [CW-1:0]   nc;
   logic [AW-1:0]   nb_addr, cell_addr;
   logic [3:0]      nb_total;
   logic [1:0]      life_new;
   logic            col_last, row_last;

   always_comb begin
      rlo = (k_ff < 4'd3);
      rhi = (k_ff >= 4'd6) && (k_ff < 4'd9);
      case (k_ff)
         4'd0, 4'd3, 4'd6: begin
            clo = 1'b1;
            chi = 1'b0;
         end
         4'd2, 4'd5, 4'd8: begin
            clo = 1'b0;
            chi = 1'b1;
         end
         default: begin
            clo = 1'b0;
            chi = 1'b0;
         end
      endcase
      r_p1  = SZRW'(r_ff) + 1'b1;
      c_p1  = SZCW'(c_ff) + 1'b1;
      nb_in = !(rlo && (r_ff == '0)) && !(rhi && (r_p1 >= rows_eff)) &&
              !(clo && (c_ff == '0)) && !(chi && (c_p1 >= cols_eff));
      nr    = rlo ? r_ff - 1'b1 : (rhi ? r_ff + 1'b1 : r_ff);
      nc    = clo ? c_ff - 1'b1 : (chi ? c_ff + 1'b1 : c_ff);
      nb_addr   = AW'(nr) * AW'(MAX_COLS) + AW'(nc);
      cell_addr = AW'(r_ff) * AW'(MAX_COLS) + AW'(c_ff);
      // last read arrives in the final slot of the walk
      nb_total  = ncnt_ff + {3'd0, dv_ff && !dcen_ff && (hist_rd == lgu_pkg::CELL_ALIVE)};
      col_last  = (c_p1 == cols_eff);
      row_last  = (r_p1 == rows_eff);
      case (ctr_ff)
         lgu_pkg::CELL_ALIVE:
            life_new = ((nb_total == 4'd2) || (nb_total == 4'd3)) ?
                       lgu_pkg::CELL_ALIVE : lgu_pkg::CELL_EMPTY;
         lgu_pkg::CELL_EMPTY:
            life_new = (nb_total == 4'd3) ? lgu_pkg::CELL_ALIVE : lgu_pkg::CELL_EMPTY;
         default:
            life_new = ctr_ff;
      endcase
   end

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lgu_pkg::ST_CLEAR: begin
            if (cnt_ff == CNTW'(NCELLS)) state_in = lgu_pkg::ST_IDLE;
         end
         lgu_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (in_addressed && !in_inside) begin
                  state_in = lgu_pkg::ST_RSP;
               end else begin
                  case (in_type)
                     lgu_pkg::REQ_GUARD, lgu_pkg::REQ_LOAD: state_in = lgu_pkg::ST_WR;
                     lgu_pkg::REQ_READ: state_in = lgu_pkg::ST_RD;
                     lgu_pkg::REQ_STEP: state_in = lgu_pkg::ST_COPY;
                     lgu_pkg::REQ_UNDO:
                        state_in = (fill_ff == '0) ? lgu_pkg::ST_RSP : lgu_pkg::ST_REST;
                     default: state_in = lgu_pkg::ST_RSP;
                  endcase
               end
            end
         end
         lgu_pkg::ST_WR: begin
            state_in = (do_write && (val_ff != grid_rd)) ? lgu_pkg::ST_CMP : lgu_pkg::ST_RSP;
         end
         lgu_pkg::ST_RD: state_in = lgu_pkg::ST_RSP;
         lgu_pkg::ST_COPY: begin
            if (sweep_done) state_in = lgu_pkg::ST_LIFE;
         end
         lgu_pkg::ST_LIFE: begin
            if ((k_ff == 4'd9) && col_last && row_last) state_in = lgu_pkg::ST_CMP;
         end
         lgu_pkg::ST_REST: begin
            if (sweep_done) state_in = lgu_pkg::ST_CMP;
         end
         lgu_pkg::ST_CMP: begin
            if (sweep_done) state_in = lgu_pkg::ST_RSP;
         end
         lgu_pkg::ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) state_in = lgu_pkg::ST_IDLE;
         end
         default: state_in = lgu_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------ memory port control
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      grid_we    = 1'b0;
      grid_wa    = paddr_ff;
      grid_wd    = hist_rd;
      grid_ra    = cnt_ff[AW-1:0];
      hist_we    = 1'b0;
      hist_wa    = hist_addr(lslot_ff, paddr_ff);
      hist_wd    = grid_rd;
      hist_ra    = hist_addr(top_dec, cnt_ff[AW-1:0]);
      case (state_ff)
         lgu_pkg::ST_CLEAR: begin
            grid_we = (cnt_ff < CNTW'(NCELLS));
            grid_wa = cnt_ff[AW-1:0];
            grid_wd = lgu_pkg::CELL_EMPTY;
         end
         lgu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            grid_ra    = in_addr;
         end
         lgu_pkg::ST_WR: begin
            grid_we = do_write && (val_ff != grid_rd);
            grid_wa = addr_ff;
            grid_wd = val_ff;
         end
         lgu_pkg::ST_COPY: begin
            hist_we = pend_ff;
         end
         lgu_pkg::ST_LIFE: begin
            hist_ra = hist_addr(lslot_ff, nb_addr);
            grid_we = (k_ff == 4'd9) && (ctr_ff != lgu_pkg::CELL_OBST);
            grid_wa = cell_addr;
            grid_wd = life_new;
         end
         lgu_pkg::ST_REST: begin
            hist_ra = hist_addr(top_ff, cnt_ff[AW-1:0]);
            grid_we = pend_ff;
         end
         lgu_pkg::ST_RSP: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_wa] <= grid_wd;
      grid_rd <= grid_mem[grid_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wa] <= hist_wd;
      hist_rd <= hist_mem[hist_ra];
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lgu_pkg::ST_CLEAR;
         rows_cfg_ff <= 6'd32;
         cols_cfg_ff <= 6'd32;
         top_ff      <= '0;
         fill_ff     <= '0;
         stable_ff   <= 1'b0;
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_addr == lgu_pkg::CSR_ROWS) rows_cfg_ff <= csr_wdata;
            else cols_cfg_ff <= csr_wdata;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            lgu_pkg::ST_IDLE: begin
               if (req_tvalid) begin
                  type_ff     <= in_type;
                  val_ff      <= in_val;
                  addr_ff     <= in_addr;
                  res_oor_ff  <= in_addressed && !in_inside;
                  res_fail_ff <= 1'b0;
                  res_read_ff <= lgu_pkg::CELL_EMPTY;
                  case (in_type)
                     lgu_pkg::REQ_CLEAR: begin
                        top_ff    <= '0;
                        fill_ff   <= '0;
                        stable_ff <= 1'b0;
                     end
                     lgu_pkg::REQ_STEP: begin
                        // push: the copy lands in the old top slot
                        lslot_ff <= top_ff;
                        top_ff   <= top_inc;
                        if (fill_ff != FW'(HIST_DEPTH)) fill_ff <= fill_ff + 1'b1;
                     end
                     lgu_pkg::REQ_UNDO: begin
                        if (fill_ff == '0) begin
                           res_fail_ff <= 1'b1;
                        end else begin
                           top_ff  <= top_dec;
                           fill_ff <= fill_ff - 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            lgu_pkg::ST_RD: res_read_ff <= grid_rd;
            lgu_pkg::ST_CLEAR: begin
               if (cnt_ff < CNTW'(NCELLS)) cnt_ff <= cnt_ff + 1'b1;
            end
            lgu_pkg::ST_COPY, lgu_pkg::ST_REST, lgu_pkg::ST_CMP: begin
               pend_ff  <= (cnt_ff < CNTW'(NCELLS));
               paddr_ff <= cnt_ff[AW-1:0];
               if (cnt_ff < CNTW'(NCELLS)) cnt_ff <= cnt_ff + 1'b1;
               if ((state_ff == lgu_pkg::ST_CMP) && pend_ff && (grid_rd != hist_rd))
                  mism_ff <= 1'b1;
               if ((state_ff == lgu_pkg::ST_CMP) && sweep_done)
                  stable_ff <= (fill_ff != '0) && !mism_ff;
            end
            lgu_pkg::ST_LIFE: begin
               // hold the flags of the read in flight, count it in the cycle after, when its data arrives
               dv_ff   <= (k_ff < 4'd9) && nb_in;
               dcen_ff <= (k_ff == 4'd4);
               if (k_ff != 4'd0) begin
                  if (dcen_ff) ctr_ff <= hist_rd;
                  else if (dv_ff && (hist_rd == lgu_pkg::CELL_ALIVE)) ncnt_ff <= ncnt_ff + 1'b1;
               end
               if (k_ff == 4'd9) begin
                  k_ff    <= '0;
                  ncnt_ff <= '0;
                  if (col_last) begin
                     c_ff <= '0;
                     r_ff <= r_ff + 1'b1;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            lgu_pkg::ST_RSP: begin
               if (rsp_load) begin
                  rsp_read_ff   <= res_read_ff;
                  rsp_stable_ff <= stable_ff;
                  rsp_fail_ff   <= res_fail_ff;
                  rsp_oor_ff    <= res_oor_ff;
                  rsp_cnt_ff    <= 3'(fill_ff);
               end
            end
            default: begin
            end
         endcase

         // restart the sweep and walk counters on every state change
         if (state_ff != state_in) begin
            cnt_ff  <= '0;
            pend_ff <= 1'b0;
            mism_ff <= 1'b0;
            r_ff    <= '0;
            c_ff    <= '0;
            k_ff    <= '0;
            ncnt_ff <= '0;
            dv_ff   <= 1'b0;
            dcen_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_oor_ff, rsp_fail_ff, rsp_stable_ff, rsp_read_ff};

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(HIST_DEPTH))
      else $error("history fill above depth");

   a_ready_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_ff)
      else $error("ready while a sweep read is in flight");

   a_stable_needs_hist: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lgu_pkg::ST_RSP) && stable_ff) |-> (fill_ff != '0))
      else $error("stable flagged with empty history");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fail_ff) |-> (rsp_cnt_ff == 3'd0))
      else $error("undo failure reported with saved grids");
`endif

endmodule
